// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands used by tlpjq_dp
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tlpjq_pkg.sv
// ---------------------------------------------------------------------------
// tlpjq_pkg
// shared types and constants of the three level priority job queue
// ---------------------------------------------------------------------------
package tlpjq_pkg;

	localparam int LEVELS           = 3;
	localparam int JOB_W            = 16;
	localparam int PRI_W            = 2;
	localparam int STATUS_W         = 3;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int JOB_ID_BITS_DEF  = 16;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_PROC = 1'b1;

	localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQ    = 3'd0,
		ST_DEQ    = 3'd1,
		ST_FULL   = 3'd2,
		ST_BADPRI = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/tlpjq_ctrl.sv
// ---------------------------------------------------------------------------
// tlpjq_ctrl
// sequencer: takes a word, runs one queue operation, hands the result over
// ---------------------------------------------------------------------------
module tlpjq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  tlpjq_pkg::dp_sts_t  sts,
	output tlpjq_pkg::ctl_cmd_t cmd
);
	import tlpjq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				// once the output register is free, the result moves into it and the next word may enter
				if (sts.out_free) begin
					cmd.load  = 1'b1;
					req_stall = 1'b0;
					if (req_valid) begin
						cmd.capture = 1'b1;
						state_nxt   = S_EXEC;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/tlpjq_dp.sv
// ---------------------------------------------------------------------------
// tlpjq_dp
// queue storage, pointers, counts and the result registers
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlpjq_dp #(
	parameter int QUEUE_DEPTH = tlpjq_pkg::QUEUE_DEPTH_DEF,
	parameter int JOB_ID_BITS = tlpjq_pkg::JOB_ID_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlpjq_pkg::ctl_cmd_t               cmd,
	output tlpjq_pkg::dp_sts_t                sts,
	input  logic                              kind,
	input  logic [tlpjq_pkg::JOB_W-1:0]       job_id,
	input  logic [tlpjq_pkg::PRI_W-1:0]       priority_req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [tlpjq_pkg::STATUS_W-1:0]    status,
	output logic [tlpjq_pkg::JOB_W-1:0]       served_job,
	output logic [tlpjq_pkg::PRI_W-1:0]       served_level
);
	import tlpjq_pkg::*;

	localparam int STORE_W   = (JOB_ID_BITS < JOB_W) ? JOB_ID_BITS : JOB_W;
	localparam int IDX_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	// current word
	logic               kind_q;
	logic [STORE_W-1:0] job_q;
	logic [PRI_W-1:0]   pri_q;

	logic [IDX_W-1:0]   head_q [LEVELS];
	logic [IDX_W-1:0]   tail_q [LEVELS];
	logic [CNT_W-1:0]   cnt_q  [LEVELS];

	logic [STORE_W-1:0] mem [MEM_DEPTH];
	logic [STORE_W-1:0] rd_q;

	status_t            res_status_q;
	logic [PRI_W-1:0]   res_level_q;
	logic [STORE_W-1:0] res_job_q;
	logic               res_mem_q;

	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [JOB_W-1:0]   rsp_job_q;
	logic [PRI_W-1:0]   rsp_level_q;

	logic [PRI_W-1:0]   deq_sel;
	logic               any_job;
	logic [PRI_W-1:0]   q_use;
	logic               full;
	logic [IDX_W-1:0]   ptr;
	logic [IDX_W-1:0]   ptr_nxt;
	logic [ADDR_W-1:0]  addr;
	logic               do_wr;
	logic               do_rd;
	status_t            res_status;
	logic [PRI_W-1:0]   res_level;

	// strict priority: lowest level number that holds a job
	always_comb begin
		any_job = 1'b1;
		if (cnt_q[0] != '0) begin
			deq_sel = 2'd0;
		end else if (cnt_q[1] != '0) begin
			deq_sel = 2'd1;
		end else begin
			deq_sel = 2'd2;
			any_job = (cnt_q[2] != '0);
		end
	end

	assign q_use   = (kind_q == KIND_PROC) ? deq_sel : (pri_q - 2'd1);
	assign full    = (cnt_q[q_use] == CNT_W'(QUEUE_DEPTH));
	assign ptr     = (kind_q == KIND_PROC) ? head_q[q_use] : tail_q[q_use];
	assign ptr_nxt = (ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	assign addr    = ADDR_W'(q_use) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);

	assign do_wr = cmd.exec && (kind_q == KIND_ADD) && (pri_q != PRI_NONE) && !full;
	assign do_rd = cmd.exec && (kind_q == KIND_PROC) && any_job;

	always_comb begin
		if (kind_q == KIND_ADD) begin
			res_level = pri_q;
			if (pri_q == PRI_NONE) begin
				res_status = ST_BADPRI;
			end else if (full) begin
				res_status = ST_FULL;
			end else begin
				res_status = ST_ENQ;
			end
		end else if (any_job) begin
			res_status = ST_DEQ;
			res_level  = deq_sel + 2'd1;
		end else begin
			res_status = ST_EMPTY;
			res_level  = PRI_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			job_q  <= STORE_W'(job_id);
			pri_q  <= priority_req;
		end
		if (cmd.exec) begin
			res_status_q <= res_status;
			res_level_q  <= res_level;
			res_job_q    <= (res_status == ST_ENQ) ? job_q : '0;
			res_mem_q    <= do_rd;
		end
	end

	// job storage, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[addr] <= job_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_rd) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < LEVELS; i++) begin
				if (do_wr && (q_use == PRI_W'(i))) begin
					tail_q[i] <= ptr_nxt;
					cnt_q[i]  <= cnt_q[i] + 1'b1;
				end
				if (do_rd && (q_use == PRI_W'(i))) begin
					head_q[i] <= ptr_nxt;
					cnt_q[i]  <= cnt_q[i] - 1'b1;
				end
			end
		end
	end

	// output register
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_status_q <= res_status_q;
			rsp_level_q  <= res_level_q;
			rsp_job_q    <= res_mem_q ? JOB_W'(rd_q) : JOB_W'(res_job_q);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign served_job   = rsp_job_q;
	assign served_level = rsp_level_q;

	`ASSERT_CLK(a_load_free, cmd.load |-> (!rsp_valid_q || !rsp_stall), "load into busy output")
	`ASSERT_CLK(a_one_port, !(do_wr && do_rd), "store written and read together")
	`ASSERT_CLK(a_cnt_range, (cnt_q[0] <= CNT_W'(QUEUE_DEPTH)) && (cnt_q[1] <= CNT_W'(QUEUE_DEPTH)) && (cnt_q[2] <= CNT_W'(QUEUE_DEPTH)), "count beyond depth")
	`ASSERT_CLK(a_deq_level, (cmd.exec && kind_q == KIND_PROC && any_job) |=> (res_level_q != PRI_NONE && res_mem_q), "dequeue without level")

endmodule

// File: rtl/three_level_priority_job_queue.sv
// ---------------------------------------------------------------------------
// three_level_priority_job_queue
// sequence: capture, execute around the job store with its registered read,
//   then load into the output register, where the next word may enter; a new
//   word is not taken during execute, and output stalls hold the load back
// reset: arst_n clears all pointers and counts, the store holds no data
// ---------------------------------------------------------------------------
module three_level_priority_job_queue #(
	parameter int QUEUE_DEPTH = tlpjq_pkg::QUEUE_DEPTH_DEF,
	parameter int JOB_ID_BITS = tlpjq_pkg::JOB_ID_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              kind,
	input  logic [tlpjq_pkg::JOB_W-1:0]       job_id,
	input  logic [tlpjq_pkg::PRI_W-1:0]       priority_req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [tlpjq_pkg::STATUS_W-1:0]    status,
	output logic [tlpjq_pkg::JOB_W-1:0]       served_job,
	output logic [tlpjq_pkg::PRI_W-1:0]       served_level
);
	import tlpjq_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	tlpjq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlpjq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.JOB_ID_BITS (JOB_ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.job_id       (job_id),
		.priority_req (priority_req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.served_job   (served_job),
		.served_level (served_level)
	);

endmodule
